// ----- rtl/core/msc_pkg.sv -----
// Shared types and constants for the modulus switch datapath.
`default_nettype none

package msc_pkg;

   // Width of each modulus register.
   localparam int MOD_W = 63;

   // Width of one partial-product operand, half the multiplier operand width.
   localparam int MUL_HALF = 32;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_SOURCE_MODULUS = 1'b0,
      CSR_TARGET_MODULUS = 1'b1
   } csr_index_type;

   // Sideband that travels with each request through the pipeline.
   typedef struct packed {
      logic valid;
      logic neg;
      logic parity;
   } tag_type;

endpackage

`default_nettype wire

// ----- rtl/core/msc_mul.sv -----
// Three-stage magnitude-by-modulus multiplier built from 32x32 partial products.
`default_nettype none

module msc_mul #(
   parameter int COEFF_BITS = 64
) (
   input  wire                                             clock,
   input  wire                                             reset,
   input  wire                                             advance,
   input  msc_pkg::tag_type                                up_tag,
   input  wire [COEFF_BITS-1:0]                            up_mag,
   input  wire [msc_pkg::MOD_W-1:0]                        factor,
   output msc_pkg::tag_type                                dn_tag,
   output logic [COEFF_BITS+msc_pkg::MOD_W-2:0]            dn_prod
);
   import msc_pkg::*;

   localparam int PROD_W = COEFF_BITS + MOD_W - 1;
   localparam int MUL_W  = 2 * MUL_HALF;
   localparam int WIDE_W = 2 * MUL_W;

   logic [MUL_W-1:0]  a_ext;
   logic [MUL_W-1:0]  b_ext;

   logic [MUL_W-1:0]  p00_in, p01_in, p10_in, p11_in;
   logic [MUL_W-1:0]  s1_p00_ff, s1_p01_ff, s1_p10_ff, s1_p11_ff;
   tag_type           s1_tag_ff;

   logic [MUL_W:0]    mid_in;
   logic [MUL_W:0]    s2_mid_ff;
   logic [MUL_W-1:0]  s2_p00_ff, s2_p11_ff;
   tag_type           s2_tag_ff;

   logic [WIDE_W-1:0] wide_sum;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] s3_prod_ff;
   tag_type           s3_tag_ff;

   assign a_ext = MUL_W'(up_mag);
   assign b_ext = MUL_W'(factor);

   assign p00_in = a_ext[MUL_HALF-1:0]     * b_ext[MUL_HALF-1:0];
   assign p01_in = a_ext[MUL_HALF-1:0]     * b_ext[MUL_W-1:MUL_HALF];
   assign p10_in = a_ext[MUL_W-1:MUL_HALF] * b_ext[MUL_HALF-1:0];
   assign p11_in = a_ext[MUL_W-1:MUL_HALF] * b_ext[MUL_W-1:MUL_HALF];

   assign mid_in = {1'b0, s1_p01_ff} + {1'b0, s1_p10_ff};

   // Cross terms land one half-word up.
   assign wide_sum = {s2_p11_ff, s2_p00_ff} + WIDE_W'({s2_mid_ff, {MUL_HALF{1'b0}}});
   assign prod_in  = wide_sum[PROD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else if (advance) begin
         s1_tag_ff <= up_tag;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_p00_ff  <= p00_in;
         s1_p01_ff  <= p01_in;
         s1_p10_ff  <= p10_in;
         s1_p11_ff  <= p11_in;
         s2_p00_ff  <= s1_p00_ff;
         s2_p11_ff  <= s1_p11_ff;
         s2_mid_ff  <= mid_in;
         s3_prod_ff <= prod_in;
      end
   end

   assign dn_tag  = s3_tag_ff;
   assign dn_prod = s3_prod_ff;

endmodule

`default_nettype wire

// ----- rtl/core/msc_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per pass.
`default_nettype none

module msc_div_cell #(
   parameter int PROD_W = 126
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       advance,
   input  wire [msc_pkg::MOD_W-1:0]  divisor,
   input  msc_pkg::tag_type          up_tag,
   input  wire [msc_pkg::MOD_W-1:0]  up_rem,
   input  wire [PROD_W-1:0]          up_work,
   output msc_pkg::tag_type          dn_tag,
   output logic [msc_pkg::MOD_W-1:0] dn_rem,
   output logic [PROD_W-1:0]         dn_work
);
   import msc_pkg::*;

   logic [MOD_W:0]    trial;
   logic [MOD_W+1:0]  diff;
   logic              fits;
   logic [MOD_W-1:0]  rem_in;
   logic [PROD_W-1:0] work_in;

   logic [MOD_W-1:0]  rem_ff;
   logic [PROD_W-1:0] work_ff;
   tag_type           tag_ff;

   // Shift the next dividend bit into the partial remainder.
   assign trial = {up_rem, up_work[PROD_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor};
   assign fits  = ~diff[MOD_W+1];

   assign rem_in  = fits ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
   // Dividend bits leave at the top, quotient bits enter at the bottom.
   assign work_in = {up_work[PROD_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= up_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

   assign dn_tag  = tag_ff;
   assign dn_rem  = rem_ff;
   assign dn_work = work_ff;

endmodule

`default_nettype wire

// ----- rtl/core/msc_fix.sv -----
// Floor correction, parity step toward zero and saturation of the quotient.
`default_nettype none

module msc_fix #(
   parameter int COEFF_BITS = 64
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  advance,
   input  msc_pkg::tag_type                     up_tag,
   input  wire [COEFF_BITS+msc_pkg::MOD_W-2:0]  up_quo,
   input  wire [msc_pkg::MOD_W-1:0]             up_rem,
   output msc_pkg::tag_type                     dn_tag,
   output logic signed [COEFF_BITS-1:0]         dn_result
);
   import msc_pkg::*;

   localparam int PROD_W = COEFF_BITS + MOD_W - 1;
   localparam int HI_W   = PROD_W - COEFF_BITS + 1;

   logic [PROD_W-1:0]     t1_in;
   logic [PROD_W-1:0]     t1_ff;
   tag_type               p1_tag_ff;

   logic                  step_down;
   logic [PROD_W-1:0]     t2_in;
   logic [PROD_W-1:0]     t2_ff;
   tag_type               p2_tag_ff;

   logic [HI_W-1:0]       hi;
   logic                  pos_sat;
   logic                  neg_sat;
   logic [COEFF_BITS-1:0] mag_sat;

   // Floor of a negative product: an inexact magnitude grows by one.
   assign t1_in = up_quo + PROD_W'(up_tag.neg && (|up_rem));

   // Parity mismatch on a nonzero value: step one toward zero.
   assign step_down = (t1_ff[0] != p1_tag_ff.parity) && (|t1_ff);
   assign t2_in     = t1_ff - PROD_W'(step_down);

   assign hi      = t2_ff[PROD_W-1:COEFF_BITS-1];
   assign pos_sat = |hi;
   assign neg_sat = (hi > HI_W'(1)) || ((hi == HI_W'(1)) && (|t2_ff[COEFF_BITS-2:0]));

   always_comb begin
      if (p2_tag_ff.neg) begin
         mag_sat   = neg_sat ? {1'b1, {(COEFF_BITS-1){1'b0}}} : t2_ff[COEFF_BITS-1:0];
         dn_result = $signed(~mag_sat + 1'b1);
      end else begin
         mag_sat   = pos_sat ? {1'b0, {(COEFF_BITS-1){1'b1}}} : t2_ff[COEFF_BITS-1:0];
         dn_result = $signed(mag_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_tag_ff <= '0;
         p2_tag_ff <= '0;
      end else if (advance) begin
         p1_tag_ff <= up_tag;
         p2_tag_ff <= p1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_ff <= t1_in;
         t2_ff <= t2_in;
      end
   end

   assign dn_tag = p2_tag_ff;

endmodule

`default_nettype wire

// ----- rtl/core/modulus_switch_coefficient.sv -----
// Top level: pipelined modulus switch of one signed coefficient per cycle while req_ready is high.
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_ready  req_coeff_in  (COEFF_BITS, signed)
//   rsp_         out         rsp_valid/rsp_ready  rsp_coeff_out (COEFF_BITS, signed)
//   csr_         in          csr_wr_en            csr_index, csr_wr_data (63 bits)
//
// One request per cycle. The pipeline runs through the input stage, three
// multiplier stages, one division cell per quotient bit (COEFF_BITS + 62), two
// correction stages and the output register; the division cell chain is its longest part.
// Reset clears all valid flags and sets both moduli to 1.
// A stalled output lets the pipeline advance once more into a one-entry skid
// register; while that is full the pipeline holds and req_ready is low.
`default_nettype none

module modulus_switch_coefficient #(
   parameter int COEFF_BITS = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire signed [COEFF_BITS-1:0]      req_coeff_in,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic signed [COEFF_BITS-1:0]     rsp_coeff_out,
   input  wire                              csr_wr_en,
   input  msc_pkg::csr_index_type           csr_index,
   input  wire [msc_pkg::MOD_W-1:0]         csr_wr_data
);
   import msc_pkg::*;

   localparam int PROD_W = COEFF_BITS + MOD_W - 1;

   logic [MOD_W-1:0]       source_ff;
   logic [MOD_W-1:0]       target_ff;

   logic                   pipe_adv;

   logic [COEFF_BITS-1:0]  raw_coeff;
   logic [COEFF_BITS-1:0]  s0_mag_in;
   logic [COEFF_BITS-1:0]  s0_mag_ff;
   tag_type                s0_tag_in;
   tag_type                s0_tag_ff;

   tag_type                mul_tag;
   logic [PROD_W-1:0]      mul_prod;

   tag_type                tag_chain  [PROD_W+1];
   logic [MOD_W-1:0]       rem_chain  [PROD_W+1];
   logic [PROD_W-1:0]      work_chain [PROD_W+1];

   tag_type                fix_tag;
   logic signed [COEFF_BITS-1:0] fix_result;
   logic                   take_in;

   logic                   rsp_valid_in, rsp_valid_ff;
   logic                   skid_valid_in, skid_valid_ff;
   logic signed [COEFF_BITS-1:0] rsp_data_in, rsp_data_ff;
   logic signed [COEFF_BITS-1:0] skid_data_in, skid_data_ff;
   logic                   rsp_load;
   logic                   skid_load;

   // Moduli; a zero source modulus divides as one.
   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= MOD_W'(1);
         target_ff <= MOD_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SOURCE_MODULUS: begin
               source_ff <= (csr_wr_data == '0) ? MOD_W'(1) : csr_wr_data;
            end
            CSR_TARGET_MODULUS: begin
               target_ff <= csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign pipe_adv  = ~skid_valid_ff;
   assign req_ready = pipe_adv;

   // Input stage: split sign and magnitude.
   assign raw_coeff        = $unsigned(req_coeff_in);
   assign s0_mag_in        = raw_coeff[COEFF_BITS-1] ? (~raw_coeff + 1'b1) : raw_coeff;
   assign s0_tag_in.valid  = req_valid;
   assign s0_tag_in.neg    = raw_coeff[COEFF_BITS-1];
   assign s0_tag_in.parity = raw_coeff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_tag_ff <= '0;
      end else if (pipe_adv) begin
         s0_tag_ff <= s0_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s0_mag_ff <= s0_mag_in;
      end
   end

   msc_mul #(
      .COEFF_BITS (COEFF_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .advance (pipe_adv),
      .up_tag  (s0_tag_ff),
      .up_mag  (s0_mag_ff),
      .factor  (target_ff),
      .dn_tag  (mul_tag),
      .dn_prod (mul_prod)
   );

   assign tag_chain[0]  = mul_tag;
   assign rem_chain[0]  = '0;
   assign work_chain[0] = mul_prod;

   for (genvar k = 0; k < PROD_W; k++) begin : g_cell
      msc_div_cell #(
         .PROD_W (PROD_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (pipe_adv),
         .divisor (source_ff),
         .up_tag  (tag_chain[k]),
         .up_rem  (rem_chain[k]),
         .up_work (work_chain[k]),
         .dn_tag  (tag_chain[k+1]),
         .dn_rem  (rem_chain[k+1]),
         .dn_work (work_chain[k+1])
      );
   end

   msc_fix #(
      .COEFF_BITS (COEFF_BITS)
   ) u_fix (
      .clock     (clock),
      .reset     (reset),
      .advance   (pipe_adv),
      .up_tag    (tag_chain[PROD_W]),
      .up_quo    (work_chain[PROD_W]),
      .up_rem    (rem_chain[PROD_W]),
      .dn_tag    (fix_tag),
      .dn_result (fix_result)
   );

   // Output register with a one-entry skid behind it.
   assign take_in = fix_tag.valid && pipe_adv;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_data_in   = fix_result;
      skid_data_in  = fix_result;
      rsp_load      = 1'b0;
      skid_load     = 1'b0;
      if (rsp_ready || !rsp_valid_ff) begin
         rsp_load = 1'b1;
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = take_in;
         end
      end else if (take_in) begin
         skid_valid_in = 1'b1;
         skid_load     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (skid_load) begin
         skid_data_ff <= skid_data_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_coeff_out = rsp_data_ff;

`ifndef ASSERT_OFF
   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a request while the output register is empty");

   a_skid_fill_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid filled without a stalled output");

   a_pipe_frozen : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(fix_tag))
      else $error("pipeline moved while the skid was full");
`endif

endmodule

`default_nettype wire

// ----- verif/modulus_switch_coefficient_tb.sv -----
// Self-checking testbench for the modulus switch block, with random stalls and config phases.
`timescale 1ns / 1ps

module modulus_switch_coefficient_tb;
   import msc_pkg::*;

   localparam int COEFF_BITS = 64;
   localparam logic [63:0] COEFF_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] COEFF_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] MOD_MAX = {MOD_W{1'b1}};
   localparam int LONG_STALL_CYCLES = 400;
   localparam int LONG_STALL_AFTER = 300;
   localparam int PIPE_LATENCY = COEFF_BITS + 69;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COEFF_BITS-1:0] req_coeff_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [COEFF_BITS-1:0] rsp_coeff_out;
   logic csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_SOURCE_MODULUS;
   logic [MOD_W-1:0] csr_wr_data = '0;

   // Local copy of the moduli, changed only while the block is empty.
   logic [MOD_W-1:0] source_q = 63'd1;
   logic [MOD_W-1:0] target_p = 63'd1;

   logic [63:0] coeff_pending[$];
   logic [63:0] switched_expected[$];
   int unsigned requests_sent = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned settings_used = 0;
   bit gaps_on = 1'b1;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned long_stall_left = 0;
   bit long_stall_done = 1'b0;

   modulus_switch_coefficient #(.COEFF_BITS(COEFF_BITS)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_coeff_in  (req_coeff_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_coeff_out (rsp_coeff_out),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always #5 clock = ~clock;

   // floor(c*p/q), nudged toward zero to match the parity of c, then saturated.
   function automatic logic [63:0] switch_modulus(input logic [63:0] c);
      logic neg;
      logic [127:0] mag, divisor, prod, quo, rem, limit;
      neg = c[63];
      mag = neg ? {64'd0, -c} : {64'd0, c};
      divisor = (source_q == '0) ? 128'd1 : {65'd0, source_q};
      prod = mag * {65'd0, target_p};
      quo = prod / divisor;
      rem = prod % divisor;
      if (neg && rem != 0)
         quo = quo + 128'd1;
      if (quo[0] != c[0] && quo != 0)
         quo = quo - 128'd1;
      limit = neg ? {64'd0, COEFF_MIN} : {64'd0, COEFF_MAX};
      if (quo > limit)
         quo = limit;
      return neg ? -quo[63:0] : quo[63:0];
   endfunction

   function automatic logic [63:0] random_coeff();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = v >> $urandom_range(1, 62);
         1: v = -(v >> $urandom_range(1, 62));
         2: v = $urandom_range(0, 1) ? COEFF_MAX - (v & 64'hFF) : COEFF_MIN + (v & 64'hFF);
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [MOD_W-1:0] random_modulus(input int unsigned bits);
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[MOD_W-1:0] >> (MOD_W - bits);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 20)
         $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic write_moduli(input logic [MOD_W-1:0] q, input logic [MOD_W-1:0] p);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SOURCE_MODULUS;
      csr_wr_data <= q;
      @(posedge clock);
      csr_index <= CSR_TARGET_MODULUS;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      source_q = q;
      target_p = p;
      settings_used++;
   endtask

   // Wait until every queued request went in and every result came back.
   task automatic drain();
      do @(posedge clock);
      while (coeff_pending.size() != 0 || req_valid || switched_expected.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Driver: offer queued requests, with random idle bursts between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            switched_expected.push_back(switch_modulus(req_coeff_in));
            requests_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else if (coeff_pending.size() != 0) begin
               req_valid <= 1'b1;
               req_coeff_in <= coeff_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check results in order and throttle the result side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (switched_expected.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_coeff_out, '0);
            end else begin
               if (rsp_coeff_out !== switched_expected[0])
                  report_mismatch("coeff_out", rsp_coeff_out, switched_expected[0]);
               void'(switched_expected.pop_front());
            end
            results_checked++;
         end
         if (long_stall_left > 0) begin
            long_stall_left--;
            rsp_ready <= 1'b0;
         end else if (!long_stall_done && results_checked >= LONG_STALL_AFTER) begin
            // hold off long enough to back the pipeline up into req_ready
            long_stall_done = 1'b1;
            long_stall_left = LONG_STALL_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [63:0] extreme_values[5];
      logic [MOD_W-1:0] q, p, t;
      int unsigned k, n;
      extreme_values = '{COEFF_MIN, COEFF_MAX, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'd0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes under unit, zero and oversized moduli.
      for (k = 0; k < 5; k++) begin
         case (k)
            0: begin q = 63'd1; p = 63'd1; end
            1: begin q = 63'd0; p = 63'd5; end
            2: begin q = 63'd7; p = 63'd0; end
            3: begin q = 63'd3; p = 63'd7; end
            default: begin q = MOD_MAX; p = MOD_MAX - 63'd1; end
         endcase
         write_moduli(q, p);
         for (n = 0; n < 5; n++)
            coeff_pending.push_back(extreme_values[n]);
         drain();
      end

      // Random phases, each under its own modulus pair.
      for (k = 0; k < 8; k++) begin
         case (k)
            1: begin q = MOD_MAX; p = random_modulus($urandom_range(1, 63)); end
            2: begin
               q = random_modulus($urandom_range(1, 20));
               p = q + random_modulus($urandom_range(1, 40)) + 63'd1;
            end
            3: begin
               q = 63'($urandom_range(1, 1000));
               p = 63'($urandom_range(0, 1000));
               if (p > q) begin t = p; p = q; q = t; end
            end
            4: begin q = 63'd0; p = 63'($urandom_range(1, 9)); end
            5: begin q = MOD_MAX; p = MOD_MAX; end
            default: begin
               q = random_modulus($urandom_range(1, 63));
               p = random_modulus($urandom_range(1, 63));
               if (p > q) begin t = p; p = q; q = t; end
            end
         endcase
         // last phase runs at full rate on both sides
         gaps_on = (k != 7);
         write_moduli(q, p);
         for (n = 0; n < 250; n++)
            coeff_pending.push_back(random_coeff());
         drain();
      end

      repeat (PIPE_LATENCY + 20) @(posedge clock);
      $display("Checked %0d results of %0d requests over %0d modulus settings,",
               results_checked, requests_sent, settings_used);
      $display("  incl. zero moduli, target above source and a long result stall.");
      if (mismatch_count == 0 && switched_expected.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
